>>> rtl/byte_fifo_with_message_detect_macros.svh
// Assertion macros used by the byte FIFO top level.
`ifndef BYTE_FIFO_WITH_MESSAGE_DETECT_MACROS_SVH
`define BYTE_FIFO_WITH_MESSAGE_DETECT_MACROS_SVH

// The condition holds in the same cycle as the trigger.
`define BFMD_ASSERT_SAME(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// The condition holds in the cycle after the trigger.
`define BFMD_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

>>> rtl/bfmd_pkg.sv
// Types and constants shared by the byte FIFO with message detection.
`timescale 1ns / 1ps

package bfmd_pkg;

    // Command codes carried by each input word.
    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_GET   = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    // Error codes reported with each result word.
    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } err_t;

    // Configuration register indexes.
    localparam logic [1:0] REG_CAPACITY = 2'd0;
    localparam logic [1:0] REG_START_A  = 2'd1;
    localparam logic [1:0] REG_START_B  = 2'd2;
    localparam logic [1:0] REG_END      = 2'd3;

    // Register widths and reset values.
    localparam int CFG_W = 9;
    localparam int BYTE_W = 8;
    localparam logic [CFG_W-1:0]  CAPACITY_RST = 9'd256;
    localparam logic [BYTE_W-1:0] START_A_RST  = 8'd36;
    localparam logic [BYTE_W-1:0] START_B_RST  = 8'd33;
    localparam logic [BYTE_W-1:0] END_RST      = 8'd10;

endpackage

>>> rtl/bfmd_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module bfmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read; contents have no reset.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/byte_fifo_with_message_detect.sv
// Top level of the circular byte FIFO with sentence detection.
// The result strobe follows the command once the scan has finished; a new command is taken
// only while idle, so busy holds off the next one until then. The scan walks the stored bytes
// through the single read port and stops at the first end character or after the last byte.
// Reset clears pointers, count and control and restores the register defaults;
// the byte store is not cleared. The receiver cannot stall the result strobe.
`timescale 1ns / 1ps
`include "byte_fifo_with_message_detect_macros.svh"

module byte_fifo_with_message_detect #(
    parameter int DEPTH = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] cmd,
    input  logic [7:0] data_in,
    output logic       result_valid,
    output logic       done_res,
    output logic [1:0] error_code,
    output logic [7:0] data_out,
    output logic [8:0] fill_level,
    output logic       has_message,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [8:0] cfg_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = ($clog2(DEPTH + 1) < 9) ? $clog2(DEPTH + 1) : 9;
    localparam int XW = ((AW + 1) > CW) ? (AW + 1) : CW;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    // Pointer step with wrap at the effective capacity.
    function automatic logic [AW-1:0] adv(input logic [AW-1:0] p, input logic [CW-1:0] c);
        logic [XW-1:0] n;
        n = XW'(p) + XW'(1);
        if (n >= XW'(c))
        begin
            adv = '0;
        end
        else
        begin
            adv = n[AW-1:0];
        end
    endfunction

    // Configuration registers.
    logic [8:0] cap_reg;
    logic [7:0] start_a_reg;
    logic [7:0] start_b_reg;
    logic [7:0] end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg     <= bfmd_pkg::CAPACITY_RST;
            start_a_reg <= bfmd_pkg::START_A_RST;
            start_b_reg <= bfmd_pkg::START_B_RST;
            end_reg     <= bfmd_pkg::END_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                bfmd_pkg::REG_CAPACITY: cap_reg     <= cfg_data;
                bfmd_pkg::REG_START_A:  start_a_reg <= cfg_data[7:0];
                bfmd_pkg::REG_START_B:  start_b_reg <= cfg_data[7:0];
                bfmd_pkg::REG_END:      end_reg     <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Effective capacity: zero acts as one, anything above the store depth as the depth.
    logic [CW-1:0] cap_eff;

    always_comb
    begin
        if (cap_reg == 9'd0)
        begin
            cap_eff = CW'(1);
        end
        else if (32'(cap_reg) > DEPTH)
        begin
            cap_eff = CW'(DEPTH);
        end
        else
        begin
            cap_eff = cap_reg[CW-1:0];
        end
    end

    // Byte store.
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    bfmd_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Control state and registered results.
    state_t          state_reg, state_next;
    logic [AW-1:0]   rp_reg, rp_next;
    logic [AW-1:0]   wp_reg, wp_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   scan_addr_reg, scan_addr_next;
    logic [CW-1:0]   scan_left_reg, scan_left_next;
    logic            rd_pend_reg, rd_pend_next;
    logic            get_pend_reg, get_pend_next;
    logic            seen_reg, seen_next;
    logic            done_reg, done_next;
    bfmd_pkg::err_t  err_reg, err_next;
    logic [7:0]      dout_reg, dout_next;
    logic [8:0]      level_reg, level_next;
    logic            msg_reg, msg_next;
    logic            valid_reg, valid_next;
    logic            finish;
    logic            finish_msg;

    always_comb
    begin
        state_next     = state_reg;
        rp_next        = rp_reg;
        wp_next        = wp_reg;
        count_next     = count_reg;
        scan_addr_next = scan_addr_reg;
        scan_left_next = scan_left_reg;
        rd_pend_next   = rd_pend_reg;
        get_pend_next  = get_pend_reg;
        seen_next      = seen_reg;
        done_next      = done_reg;
        err_next       = err_reg;
        dout_next      = dout_reg;
        level_next     = level_reg;
        msg_next       = msg_reg;
        valid_next     = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = wp_reg;
        mem_wdata      = data_in;
        mem_re         = 1'b0;
        mem_raddr      = scan_addr_reg;
        finish         = 1'b0;
        finish_msg     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                // Carry out the command, then scan the new contents.
                if (start)
                begin
                    done_next     = 1'b0;
                    err_next      = bfmd_pkg::ERR_OK;
                    dout_next     = 8'd0;
                    get_pend_next = 1'b0;
                    case (bfmd_pkg::cmd_t'(cmd))
                        bfmd_pkg::CMD_PUT:
                        begin
                            if (count_reg < cap_eff)
                            begin
                                mem_we     = 1'b1;
                                wp_next    = adv(wp_reg, cap_eff);
                                count_next = count_reg + CW'(1);
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                err_next = bfmd_pkg::ERR_FULL;
                            end
                        end
                        bfmd_pkg::CMD_GET:
                        begin
                            if (count_reg != '0)
                            begin
                                mem_re        = 1'b1;
                                mem_raddr     = rp_reg;
                                rp_next       = adv(rp_reg, cap_eff);
                                count_next    = count_reg - CW'(1);
                                done_next     = 1'b1;
                                get_pend_next = 1'b1;
                            end
                            else
                            begin
                                err_next = bfmd_pkg::ERR_EMPTY;
                            end
                        end
                        bfmd_pkg::CMD_CLEAR:
                        begin
                            rp_next    = '0;
                            wp_next    = '0;
                            count_next = '0;
                            done_next  = 1'b1;
                        end
                        default: ;
                    endcase
                    scan_addr_next = rp_next;
                    scan_left_next = count_next;
                    rd_pend_next   = 1'b0;
                    seen_next      = 1'b0;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // The byte removed by a get arrives in the first scan cycle.
                if (get_pend_reg)
                begin
                    dout_next     = mem_rdata;
                    get_pend_next = 1'b0;
                end
                // Examine the byte read in the previous cycle.
                if (rd_pend_reg)
                begin
                    if (mem_rdata == end_reg)
                    begin
                        finish     = 1'b1;
                        finish_msg = seen_reg;
                    end
                    else if (mem_rdata == start_a_reg || mem_rdata == start_b_reg)
                    begin
                        seen_next = 1'b1;
                    end
                end
                // Issue the next read, or stop when every stored byte has been seen.
                rd_pend_next = 1'b0;
                if (!finish)
                begin
                    if (scan_left_reg != '0)
                    begin
                        mem_re         = 1'b1;
                        mem_raddr      = scan_addr_reg;
                        scan_addr_next = adv(scan_addr_reg, cap_eff);
                        scan_left_next = scan_left_reg - CW'(1);
                        rd_pend_next   = 1'b1;
                    end
                    else
                    begin
                        finish     = 1'b1;
                        finish_msg = 1'b0;
                    end
                end
                if (finish)
                begin
                    level_next = 9'(count_reg);
                    msg_next   = finish_msg;
                    valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rp_reg        <= '0;
            wp_reg        <= '0;
            count_reg     <= '0;
            scan_addr_reg <= '0;
            scan_left_reg <= '0;
            rd_pend_reg   <= 1'b0;
            get_pend_reg  <= 1'b0;
            seen_reg      <= 1'b0;
            valid_reg     <= 1'b0;
            done_reg      <= 1'b0;
            err_reg       <= bfmd_pkg::ERR_OK;
            dout_reg      <= 8'd0;
            msg_reg       <= 1'b0;
            level_reg     <= 9'd0;
        end
        else
        begin
            state_reg     <= state_next;
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            count_reg     <= count_next;
            scan_addr_reg <= scan_addr_next;
            scan_left_reg <= scan_left_next;
            rd_pend_reg   <= rd_pend_next;
            get_pend_reg  <= get_pend_next;
            seen_reg      <= seen_next;
            valid_reg     <= valid_next;
            done_reg      <= done_next;
            err_reg       <= err_next;
            dout_reg      <= dout_next;
            msg_reg       <= msg_next;
            level_reg     <= level_next;
        end
    end

    // Output ports.
    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = valid_reg;
    assign done_res     = done_reg;
    assign error_code   = err_reg;
    assign data_out     = dout_reg;
    assign fill_level   = level_reg;
    assign has_message  = msg_reg;

    // Checks on the command sequencer.
    `BFMD_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted command did not start work")
    `BFMD_ASSERT_SAME(a_strobe_idle, valid_reg, state_reg == ST_IDLE, "result strobe while busy")
    `BFMD_ASSERT_NEXT(a_strobe_single, valid_reg, !valid_reg, "result strobe longer than one cycle")
    `BFMD_ASSERT_SAME(a_done_no_error, valid_reg && done_reg, err_reg == bfmd_pkg::ERR_OK, "done with error code")
    `BFMD_ASSERT_SAME(a_msg_not_empty, valid_reg && msg_reg, level_reg != 9'd0, "message flagged in empty FIFO")

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the byte FIFO with sentence detection.
`timescale 1ns / 1ps

module tb_top;

    localparam int DEPTH = 256;
    localparam int RANDOM_WORDS = 1750;
    localparam int QUIET_TAIL = 200;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // One result word of the block.
    typedef struct {
        logic           done;
        bfmd_pkg::err_t err;
        logic [7:0]     dout;
        logic [8:0]     level;
        logic           msg;
    } fifo_word_t;

    // One row of the directed stimulus: a command word or a register write.
    typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;
    typedef struct {
        row_kind_t  kind;
        logic [1:0] sel;
        logic [8:0] value;
        logic       typed;
        fifo_word_t want;
    } stim_row_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [1:0] cmd;
    logic [7:0] data_in;
    logic       result_valid;
    logic       done_res;
    logic [1:0] error_code;
    logic [7:0] data_out;
    logic [8:0] fill_level;
    logic       has_message;
    logic       cfg_write;
    logic [1:0] cfg_index;
    logic [8:0] cfg_data;

    // Shadow copy of the FIFO, its registers and the words still owed.
    logic [7:0]  ring [DEPTH];
    bit          ring_written [DEPTH];
    int unsigned rd_ptr;
    int unsigned wr_ptr;
    int unsigned level;
    logic [8:0]  cap_reg;
    logic [7:0]  start_a_reg;
    logic [7:0]  start_b_reg;
    logic [7:0]  end_reg;
    fifo_word_t  owed_words [$];
    stim_row_t   rows [$];
    int unsigned mismatches;
    int unsigned sentence_left;

    byte_fifo_with_message_detect #(
        .DEPTH(DEPTH)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .data_in     (data_in),
        .result_valid(result_valid),
        .done_res    (done_res),
        .error_code  (error_code),
        .data_out    (data_out),
        .fill_level  (fill_level),
        .has_message (has_message),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // Clock: 10 ns period.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard limit on the length of the run.
    initial
    begin
        #40_000_000;
        $display("Verification failed");
        $finish;
    end

    // Capacity as the block applies it: zero acts as one, above DEPTH as DEPTH.
    function automatic int unsigned eff_capacity(logic [8:0] cap);
        if (cap == 9'd0)
            return 1;
        if (cap > DEPTH)
            return DEPTH;
        return cap;
    endfunction

    function automatic int unsigned step_ptr(int unsigned p);
        int unsigned n;
        n = p + 1;
        if (n >= eff_capacity(cap_reg))
            n = 0;
        return n;
    endfunction

    // Walk the stored bytes oldest first; an end code closes the search.
    function automatic logic sentence_present();
        logic        opened;
        int unsigned idx;
        opened = 1'b0;
        idx = rd_ptr % DEPTH;
        for (int unsigned k = 0; k < level && k < DEPTH; k++)
        begin
            if (ring[idx] == end_reg)
                return opened;
            if (ring[idx] == start_a_reg || ring[idx] == start_b_reg)
                opened = 1'b1;
            idx = step_ptr(idx) % DEPTH;
        end
        return 1'b0;
    endfunction

    // Apply one command word to the shadow FIFO and return its result word.
    function automatic fifo_word_t fifo_step(logic [1:0] op, logic [7:0] din);
        fifo_word_t w;
        w.done = 1'b0;
        w.err  = bfmd_pkg::ERR_OK;
        w.dout = 8'd0;
        case (op)
            bfmd_pkg::CMD_PUT:
                if (level < eff_capacity(cap_reg))
                begin
                    ring[wr_ptr % DEPTH] = din;
                    ring_written[wr_ptr % DEPTH] = 1'b1;
                    wr_ptr = step_ptr(wr_ptr);
                    level++;
                    w.done = 1'b1;
                end
                else
                begin
                    w.err = bfmd_pkg::ERR_FULL;
                end
            bfmd_pkg::CMD_GET:
                if (level > 0)
                begin
                    w.dout = ring[rd_ptr % DEPTH];
                    rd_ptr = step_ptr(rd_ptr);
                    level--;
                    w.done = 1'b1;
                end
                else
                begin
                    w.err = bfmd_pkg::ERR_EMPTY;
                end
            bfmd_pkg::CMD_CLEAR:
            begin
                rd_ptr = 0;
                wr_ptr = 0;
                level = 0;
                w.done = 1'b1;
            end
            default:
            begin
            end
        endcase
        w.level = level[8:0];
        w.msg = sentence_present();
        return w;
    endfunction

    // A new capacity must never steer a read onto a byte that was never stored.
    function automatic bit capacity_change_safe(logic [8:0] cap);
        if (level == 0 && rd_ptr == wr_ptr)
            return 1'b1;
        if (!ring_written[rd_ptr % DEPTH])
            return 1'b0;
        for (int unsigned i = 0; i < eff_capacity(cap); i++)
            if (!ring_written[i])
                return 1'b0;
        return 1'b1;
    endfunction

    // Byte for a put: mostly framed sentences, with some noise.
    function automatic logic [7:0] next_put_byte();
        if ($urandom_range(0, 6) == 0)
            return 8'($urandom);
        if (sentence_left == 0)
        begin
            sentence_left = $urandom_range(1, 7);
            return $urandom_range(0, 1) ? start_a_reg : start_b_reg;
        end
        sentence_left--;
        if (sentence_left == 0)
            return end_reg;
        return 8'($urandom);
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic add_row(row_kind_t kind, logic [1:0] sel, logic [8:0] value,
                           logic typed, logic done, bfmd_pkg::err_t err, logic [7:0] dout,
                           logic [8:0] lvl, logic msg);
        stim_row_t r;
        r.kind = kind;
        r.sel = sel;
        r.value = value;
        r.typed = typed;
        r.want.done = done;
        r.want.err = err;
        r.want.dout = dout;
        r.want.level = lvl;
        r.want.msg = msg;
        rows.push_back(r);
    endtask

    task automatic pause_sender(int unsigned n);
        repeat (n)
        begin
            @(negedge clk);
            start = 1'b0;
        end
    endtask

    // Offer one word and hold it until the block takes it.
    task automatic send_word(logic [1:0] op, logic [7:0] din, logic typed, fifo_word_t want);
        fifo_word_t w;
        @(negedge clk);
        start = 1'b1;
        cmd = op;
        data_in = din;
        do
            @(posedge clk);
        while (busy);
        w = fifo_step(op, din);
        if (typed)
            owed_words.push_back(want);
        else
            owed_words.push_back(w);
    endtask

    // Stop sending and wait until every owed word has come back.
    task automatic wait_idle();
        pause_sender(1);
        while (owed_words.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [8:0] val);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(posedge clk);
        case (idx)
            bfmd_pkg::REG_CAPACITY: cap_reg = val;
            bfmd_pkg::REG_START_A:  start_a_reg = val[7:0];
            bfmd_pkg::REG_START_B:  start_b_reg = val[7:0];
            bfmd_pkg::REG_END:      end_reg = val[7:0];
            default:                ;
        endcase
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    // Capacity write from idle; empty the FIFO first where it would not be safe.
    task automatic set_capacity(logic [8:0] cap);
        fifo_word_t none;
        none = '{1'b0, bfmd_pkg::ERR_OK, 8'd0, 9'd0, 1'b0};
        wait_idle();
        if (!capacity_change_safe(cap))
        begin
            send_word(bfmd_pkg::CMD_CLEAR, 8'($urandom), 1'b0, none);
            wait_idle();
        end
        write_reg(bfmd_pkg::REG_CAPACITY, cap);
    endtask

    // A stretch of random words under the current settings.
    task automatic run_phase(int unsigned words, int unsigned put_weight,
                             bit with_noise, bit with_gaps);
        int unsigned r;
        logic [1:0]  op;
        logic [7:0]  din;
        fifo_word_t  none;
        none = '{1'b0, bfmd_pkg::ERR_OK, 8'd0, 9'd0, 1'b0};
        for (int unsigned i = 0; i < words; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < put_weight)
                op = bfmd_pkg::CMD_PUT;
            else if (!with_noise || r < 95)
                op = bfmd_pkg::CMD_GET;
            else if (r < 98)
                op = bfmd_pkg::CMD_CLEAR;
            else
                op = CMD_UNUSED;
            din = (op == bfmd_pkg::CMD_PUT) ? next_put_byte() : 8'($urandom);
            send_word(op, din, 1'b0, none);
            if (with_gaps && $urandom_range(0, 3) == 0)
                pause_sender($urandom_range(1, 10));
        end
    endtask

    // Compare every result word with the oldest one owed.
    always @(posedge clk)
    begin : check_results
        fifo_word_t want;
        if (rst_n && result_valid)
        begin
            if (owed_words.size() == 0)
            begin
                report_mismatch("result word with none expected");
            end
            else
            begin
                want = owed_words.pop_front();
                if (done_res !== want.done)
                    report_mismatch($sformatf("done_res expected %0d, got %0d",
                                              want.done, done_res));
                if (error_code !== want.err)
                    report_mismatch($sformatf("error_code expected %0d, got %0d",
                                              want.err, error_code));
                if (data_out !== want.dout)
                    report_mismatch($sformatf("data_out expected %0d, got %0d",
                                              want.dout, data_out));
                if (fill_level !== want.level)
                    report_mismatch($sformatf("fill_level expected %0d, got %0d",
                                              want.level, fill_level));
                if (has_message !== want.msg)
                    report_mismatch($sformatf("has_message expected %0d, got %0d",
                                              want.msg, has_message));
            end
        end
    end

    // Main sequence: reset, directed table, random phases, drain.
    initial
    begin : stimulus
        int unsigned sent;
        int unsigned words;
        int unsigned pick;
        bit          quiet;
        logic [8:0]  cap;

        rst_n = 1'b0;
        start = 1'b0;
        cmd = bfmd_pkg::CMD_PUT;
        data_in = 8'd0;
        cfg_write = 1'b0;
        cfg_index = bfmd_pkg::REG_CAPACITY;
        cfg_data = 9'd0;
        cap_reg = bfmd_pkg::CAPACITY_RST;
        start_a_reg = bfmd_pkg::START_A_RST;
        start_b_reg = bfmd_pkg::START_B_RST;
        end_reg = bfmd_pkg::END_RST;
        rd_ptr = 0;
        wr_ptr = 0;
        level = 0;
        mismatches = 0;
        sentence_left = 0;
        for (int i = 0; i < DEPTH; i++)
        begin
            ring[i] = 8'd0;
            ring_written[i] = 1'b0;
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table; typed rows carry results that follow straight from the rules.
        add_row(ROW_WORD, bfmd_pkg::CMD_GET,   9'd0,   1, 0, bfmd_pkg::ERR_EMPTY, 8'd0, 9'd0, 0);
        add_row(ROW_WORD, CMD_UNUSED,          9'd255, 1, 0, bfmd_pkg::ERR_OK,  8'd0,  9'd0, 0);
        add_row(ROW_WORD, bfmd_pkg::CMD_PUT,   9'd0,   1, 1, bfmd_pkg::ERR_OK,  8'd0,  9'd1, 0);
        add_row(ROW_WORD, bfmd_pkg::CMD_PUT,   9'd36,  1, 1, bfmd_pkg::ERR_OK,  8'd0,  9'd2, 0);
        add_row(ROW_WORD, bfmd_pkg::CMD_PUT,   9'd255, 0, 0, bfmd_pkg::ERR_OK,  8'd0,  9'd0, 0);
        add_row(ROW_WORD, bfmd_pkg::CMD_PUT,   9'd10,  1, 1, bfmd_pkg::ERR_OK,  8'd0,  9'd4, 1);
        add_row(ROW_WORD, bfmd_pkg::CMD_GET,   9'd0,   1, 1, bfmd_pkg::ERR_OK,  8'd0,  9'd3, 1);
        add_row(ROW_WORD, bfmd_pkg::CMD_GET,   9'd0,   1, 1, bfmd_pkg::ERR_OK,  8'd36, 9'd2, 0);
        add_row(ROW_WORD, bfmd_pkg::CMD_PUT,   9'd33,  1, 1, bfmd_pkg::ERR_OK,  8'd0,  9'd3, 0);
        add_row(ROW_WORD, bfmd_pkg::CMD_CLEAR, 9'd0,   1, 1, bfmd_pkg::ERR_OK,  8'd0,  9'd0, 0);
        add_row(ROW_WORD, bfmd_pkg::CMD_PUT,   9'd10,  0, 0, bfmd_pkg::ERR_OK,  8'd0,  9'd0, 0);
        add_row(ROW_WORD, bfmd_pkg::CMD_CLEAR, 9'd0,   0, 0, bfmd_pkg::ERR_OK,  8'd0,  9'd0, 0);
        // Capacity of zero behaves as a single entry.
        add_row(ROW_REG, bfmd_pkg::REG_CAPACITY, 9'd0, 0, 0, bfmd_pkg::ERR_OK,  8'd0,  9'd0, 0);
        add_row(ROW_WORD, bfmd_pkg::CMD_PUT,   9'd33,  1, 1, bfmd_pkg::ERR_OK,  8'd0,  9'd1, 0);
        add_row(ROW_WORD, bfmd_pkg::CMD_PUT,   9'd10,  1, 0, bfmd_pkg::ERR_FULL, 8'd0, 9'd1, 0);
        add_row(ROW_WORD, bfmd_pkg::CMD_GET,   9'd0,   1, 1, bfmd_pkg::ERR_OK,  8'd33, 9'd0, 0);
        // End code equal to a start code: the byte counts as an end.
        add_row(ROW_REG,  bfmd_pkg::REG_END,   9'd33,  0, 0, bfmd_pkg::ERR_OK,  8'd0,  9'd0, 0);
        add_row(ROW_WORD, bfmd_pkg::CMD_PUT,   9'd33,  1, 1, bfmd_pkg::ERR_OK,  8'd0,  9'd1, 0);
        add_row(ROW_WORD, bfmd_pkg::CMD_CLEAR, 9'd0,   1, 1, bfmd_pkg::ERR_OK,  8'd0,  9'd0, 0);
        // Capacity above DEPTH is clipped.
        add_row(ROW_REG, bfmd_pkg::REG_CAPACITY, 9'd511, 0, 0, bfmd_pkg::ERR_OK, 8'd0, 9'd0, 0);
        add_row(ROW_WORD, bfmd_pkg::CMD_PUT,   9'd36,  0, 0, bfmd_pkg::ERR_OK,  8'd0,  9'd0, 0);
        add_row(ROW_WORD, bfmd_pkg::CMD_PUT,   9'd33,  1, 1, bfmd_pkg::ERR_OK,  8'd0,  9'd2, 1);
        add_row(ROW_REG,  bfmd_pkg::REG_START_A, 9'd255, 0, 0, bfmd_pkg::ERR_OK, 8'd0, 9'd0, 0);
        add_row(ROW_REG,  bfmd_pkg::REG_END,   9'd0,   0, 0, bfmd_pkg::ERR_OK,  8'd0,  9'd0, 0);
        add_row(ROW_WORD, bfmd_pkg::CMD_PUT,   9'd0,   0, 0, bfmd_pkg::ERR_OK,  8'd0,  9'd0, 0);
        add_row(ROW_WORD, bfmd_pkg::CMD_PUT,   9'd255, 0, 0, bfmd_pkg::ERR_OK,  8'd0,  9'd0, 0);
        add_row(ROW_WORD, bfmd_pkg::CMD_GET,   9'd0,   0, 0, bfmd_pkg::ERR_OK,  8'd0,  9'd0, 0);
        add_row(ROW_WORD, bfmd_pkg::CMD_CLEAR, 9'd0,   0, 0, bfmd_pkg::ERR_OK,  8'd0,  9'd0, 0);
        // Back to the reset settings.
        add_row(ROW_REG, bfmd_pkg::REG_CAPACITY, 9'd256, 0, 0, bfmd_pkg::ERR_OK, 8'd0, 9'd0, 0);
        add_row(ROW_REG,  bfmd_pkg::REG_START_A, 9'd36, 0, 0, bfmd_pkg::ERR_OK, 8'd0,  9'd0, 0);
        add_row(ROW_REG,  bfmd_pkg::REG_START_B, 9'd33, 0, 0, bfmd_pkg::ERR_OK, 8'd0,  9'd0, 0);
        add_row(ROW_REG,  bfmd_pkg::REG_END,   9'd10,  0, 0, bfmd_pkg::ERR_OK,  8'd0,  9'd0, 0);

        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_REG)
            begin
                if (rows[i].sel == bfmd_pkg::REG_CAPACITY)
                begin
                    set_capacity(rows[i].value);
                end
                else
                begin
                    wait_idle();
                    write_reg(rows[i].sel, rows[i].value);
                end
            end
            else
            begin
                send_word(rows[i].sel, rows[i].value[7:0], rows[i].typed, rows[i].want);
            end
        end

        // Fill a full-depth FIFO to the brim so that full refusals and level 256 occur.
        set_capacity(9'd256);
        run_phase(320, 97, 1'b0, 1'b1);
        sent = 320;

        // Random phases, each after an optional change of settings written from idle.
        while (sent < RANDOM_WORDS)
        begin
            wait_idle();
            pick = $urandom_range(0, 19);
            case (pick)
                0:       cap = 9'd0;
                1:       cap = 9'd1;
                2:       cap = 9'd256;
                3:       cap = 9'($urandom_range(257, 511));
                4:       cap = 9'd511;
                5:       cap = 9'($urandom_range(0, 511));
                default: cap = 9'($urandom_range(2, 12));
            endcase
            if ($urandom_range(0, 2) != 0)
                set_capacity(cap);
            case ($urandom_range(0, 5))
                0:
                begin
                    write_reg(bfmd_pkg::REG_START_A, 9'(bfmd_pkg::START_A_RST));
                    write_reg(bfmd_pkg::REG_START_B, 9'(bfmd_pkg::START_B_RST));
                    write_reg(bfmd_pkg::REG_END, 9'(bfmd_pkg::END_RST));
                end
                1:
                begin
                    write_reg(bfmd_pkg::REG_START_A, 9'($urandom_range(0, 255)));
                    write_reg(bfmd_pkg::REG_START_B, 9'($urandom_range(0, 255)));
                    write_reg(bfmd_pkg::REG_END, 9'($urandom_range(0, 255)));
                end
                2:
                    write_reg(bfmd_pkg::REG_END, 9'(start_a_reg));
                default:
                begin
                end
            endcase
            words = $urandom_range(30, 120);
            if (words > RANDOM_WORDS - sent)
                words = RANDOM_WORDS - sent;
            quiet = (RANDOM_WORDS - sent) <= QUIET_TAIL;
            run_phase(words, $urandom_range(35, 80), 1'b1,
                      !quiet && $urandom_range(0, 3) != 0);
            sent += words;
        end

        wait_idle();
        repeat (DEPTH + 4) @(posedge clk);
        if (mismatches == 0 && owed_words.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
